/* sv/assert_macros.svh */
// Assertion macros used by the sequencer core module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/pes_pkg.sv */
// Types, codes and constants of the photogate experiment sequencer
package pes_pkg;

    localparam int OPT_W   = 8;
    localparam int TS_W    = 48;
    localparam int DATA_W  = 8;
    localparam int IDX_W   = 3;
    localparam int STAGE_W = 3;

    localparam int CLEAR_SAMPLES_DEF = 5;

    localparam logic [OPT_W-1:0] OPTION_LOW_RST     = 8'd0;
    localparam logic [OPT_W-1:0] OPTION_HIGH_RST    = 8'd255;
    localparam logic [OPT_W-1:0] OPTION_DEFAULT_RST = 8'd0;
    localparam logic             BEAM_GUARD_RST     = 1'b1;
    localparam logic             ACCUMULATE_RST     = 1'b0;

    localparam logic [IDX_W-1:0] REG_OPTION_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_OPTION_HIGH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_OPTION_DEFAULT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BEAM_GUARD      = 3'd3;
    localparam logic [IDX_W-1:0] REG_ACCUMULATE_MODE = 3'd4;

    typedef enum logic [STAGE_W-1:0] {
        ST_CONFIG  = 3'd0,
        ST_WAITING = 3'd1,
        ST_TIMING  = 3'd2,
        ST_DONE    = 3'd3,
        ST_ERROR   = 3'd4,
        ST_EXIT    = 3'd5
    } t_stage;

    typedef enum logic [1:0] {
        OP_CMD   = 2'd0,
        OP_PULSE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CMD_UP     = 2'd0,
        CMD_DOWN   = 2'd1,
        CMD_SELECT = 2'd2,
        CMD_BACK   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]      op;
        logic [1:0]      command;
        logic [TS_W-1:0] timestamp_us;
        logic            beam_blocked;
    } t_req;

    typedef struct packed {
        logic [STAGE_W-1:0] stage_now;
        logic [OPT_W-1:0]   option_now;
        logic [TS_W-1:0]    elapsed_us;
        logic               reading_ready;
        logic               lap_added;
    } t_res;

    typedef struct packed {
        logic [OPT_W-1:0] option_low;
        logic [OPT_W-1:0] option_high;
        logic             beam_guard;
        logic             accumulate_mode;
        logic             option_load;
        logic [OPT_W-1:0] option_load_value;
    } t_cfg;

endpackage

/* sv/pes_req_if.sv */
// Request channel: valid/ready handshake with the input item fields
interface pes_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [1:0]               command;
    logic [pes_pkg::TS_W-1:0] timestamp_us;
    logic                     beam_blocked;

    modport source (output valid, output op, output command, output timestamp_us,
                    output beam_blocked, input ready);
    modport sink (input valid, input op, input command, input timestamp_us,
                  input beam_blocked, output ready);
endinterface

/* sv/pes_res_if.sv */
// Result channel: valid/ready handshake with the result item fields
interface pes_res_if;
    logic                        valid;
    logic                        ready;
    logic [pes_pkg::STAGE_W-1:0] stage_now;
    logic [pes_pkg::OPT_W-1:0]   option_now;
    logic [pes_pkg::TS_W-1:0]    elapsed_us;
    logic                        reading_ready;
    logic                        lap_added;

    modport source (output valid, output stage_now, output option_now, output elapsed_us,
                    output reading_ready, output lap_added, input ready);
    modport sink (input valid, input stage_now, input option_now, input elapsed_us,
                  input reading_ready, input lap_added, output ready);
endinterface

/* sv/pes_cfg.sv */
// Configuration register file
module pes_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pes_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [pes_pkg::DATA_W-1:0]   i_cfg_data,
    output pes_pkg::t_cfg                o_cfg
);

    logic [pes_pkg::OPT_W-1:0] r_option_low;
    logic [pes_pkg::OPT_W-1:0] r_option_high;
    logic                      r_beam_guard;
    logic                      r_accumulate_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_option_low      <= pes_pkg::OPTION_LOW_RST;
            r_option_high     <= pes_pkg::OPTION_HIGH_RST;
            r_beam_guard      <= pes_pkg::BEAM_GUARD_RST;
            r_accumulate_mode <= pes_pkg::ACCUMULATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pes_pkg::REG_OPTION_LOW:      r_option_low      <= i_cfg_data;
                pes_pkg::REG_OPTION_HIGH:     r_option_high     <= i_cfg_data;
                pes_pkg::REG_BEAM_GUARD:      r_beam_guard      <= i_cfg_data[0];
                pes_pkg::REG_ACCUMULATE_MODE: r_accumulate_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.option_low        = r_option_low;
    assign o_cfg.option_high       = r_option_high;
    assign o_cfg.beam_guard        = r_beam_guard;
    assign o_cfg.accumulate_mode   = r_accumulate_mode;
    assign o_cfg.option_load       = i_cfg_we && (i_cfg_idx == pes_pkg::REG_OPTION_DEFAULT);
    assign o_cfg.option_load_value = i_cfg_data;

endmodule

/* sv/pes_in_stage.sv */
// Input register stage for requests
module pes_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pes_pkg::t_req  i_req,
    output logic           o_ready,
    input  logic           i_advance,
    output logic           o_valid,
    output pes_pkg::t_req  o_req
);

    logic          r_valid;
    pes_pkg::t_req r_req;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* sv/pes_core.sv */
// Stage machine, timing datapath and result register
`include "assert_macros.svh"

module pes_core #(
    parameter int CLEAR_SAMPLES = pes_pkg::CLEAR_SAMPLES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pes_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  pes_pkg::t_req  i_req,
    output logic           o_advance,
    input  logic           i_res_ready,
    output logic           o_res_valid,
    output pes_pkg::t_res  o_res
);

    localparam int CW = $clog2(CLEAR_SAMPLES + 1);
    localparam logic [CW-1:0] CLEAR_MAX = CW'(CLEAR_SAMPLES);

    pes_pkg::t_stage            r_stage, n_stage;
    logic [pes_pkg::OPT_W-1:0]  r_option, n_option;
    logic [pes_pkg::TS_W-1:0]   r_start, n_start;
    logic [pes_pkg::TS_W-1:0]   r_last, n_last;
    logic [pes_pkg::TS_W-1:0]   r_acc, n_acc;
    logic [CW-1:0]              r_clear_count, n_clear_count;
    logic                       r_seen_clear, n_seen_clear;
    logic                       r_res_valid;
    pes_pkg::t_res              r_res, n_res;

    logic                       fire;
    pes_pkg::t_op               op;
    pes_pkg::t_cmd              cmd;
    pes_pkg::t_stage            cmd_stage;
    logic [CW-1:0]              tick_count;
    logic                       tick_arm;
    logic [pes_pkg::TS_W-1:0]   interval;
    logic                       ready_flag;
    logic                       lap_flag;

    assign o_advance = !r_res_valid || i_res_ready;
    assign fire      = i_valid && o_advance;
    assign op        = pes_pkg::t_op'(i_req.op);
    assign cmd       = pes_pkg::t_cmd'(i_req.command);
    assign interval  = i_req.timestamp_us - r_start;

    always_comb begin
        cmd_stage = r_stage;
        if (cmd == pes_pkg::CMD_SELECT) begin
            cmd_stage = pes_pkg::ST_CONFIG;
        end else if (cmd == pes_pkg::CMD_BACK) begin
            cmd_stage = pes_pkg::ST_EXIT;
        end
    end

    always_comb begin
        if (i_req.beam_blocked) begin
            tick_count = '0;
        end else if (r_clear_count < CLEAR_MAX) begin
            tick_count = r_clear_count + CW'(1);
        end else begin
            tick_count = r_clear_count;
        end
        tick_arm = !i_req.beam_blocked && (tick_count >= CLEAR_MAX);
    end

    // next stage
    always_comb begin
        n_stage = r_stage;
        if (fire) begin
            unique case (r_stage)
                pes_pkg::ST_CONFIG: begin
                    if (op == pes_pkg::OP_CMD) begin
                        if (cmd == pes_pkg::CMD_SELECT) begin
                            n_stage = (i_cfg.beam_guard && i_req.beam_blocked)
                                      ? pes_pkg::ST_ERROR : pes_pkg::ST_WAITING;
                        end else if (cmd == pes_pkg::CMD_BACK) begin
                            n_stage = pes_pkg::ST_EXIT;
                        end
                    end
                end
                pes_pkg::ST_WAITING: begin
                    if (op == pes_pkg::OP_CMD) begin
                        n_stage = cmd_stage;
                    end else if (op == pes_pkg::OP_PULSE) begin
                        n_stage = pes_pkg::ST_TIMING;
                    end
                end
                pes_pkg::ST_TIMING: begin
                    if (op == pes_pkg::OP_CMD) begin
                        n_stage = cmd_stage;
                    end else if (op == pes_pkg::OP_PULSE) begin
                        n_stage = i_cfg.accumulate_mode ? pes_pkg::ST_WAITING
                                                        : pes_pkg::ST_DONE;
                    end
                end
                pes_pkg::ST_DONE: begin
                    if (op == pes_pkg::OP_CMD) begin
                        n_stage = cmd_stage;
                    end
                end
                pes_pkg::ST_ERROR: begin
                    if (op == pes_pkg::OP_CMD) begin
                        n_stage = cmd_stage;
                    end else if (op == pes_pkg::OP_TICK && tick_arm) begin
                        n_stage = pes_pkg::ST_WAITING;
                    end
                end
                pes_pkg::ST_EXIT: n_stage = pes_pkg::ST_EXIT;
                default:          n_stage = pes_pkg::ST_EXIT;
            endcase
        end
    end

    // datapath and flags
    always_comb begin
        n_option      = r_option;
        n_start       = r_start;
        n_last        = r_last;
        n_acc         = r_acc;
        n_clear_count = r_clear_count;
        n_seen_clear  = r_seen_clear;
        ready_flag    = 1'b0;
        lap_flag      = 1'b0;
        if (fire) begin
            case (r_stage)
                pes_pkg::ST_CONFIG: begin
                    if (op == pes_pkg::OP_CMD) begin
                        if (cmd == pes_pkg::CMD_UP && r_option < i_cfg.option_high) begin
                            n_option = r_option + 8'd1;
                        end else if (cmd == pes_pkg::CMD_DOWN
                                     && r_option > i_cfg.option_low) begin
                            n_option = r_option - 8'd1;
                        end
                    end
                end
                pes_pkg::ST_WAITING: begin
                    if (op == pes_pkg::OP_PULSE) begin
                        n_start = i_req.timestamp_us;
                    end
                end
                pes_pkg::ST_TIMING: begin
                    if (op == pes_pkg::OP_PULSE) begin
                        n_last = interval;
                        if (i_cfg.accumulate_mode) begin
                            n_acc    = r_acc + interval;
                            lap_flag = 1'b1;
                        end else begin
                            ready_flag = 1'b1;
                        end
                    end
                end
                pes_pkg::ST_ERROR: begin
                    if (op == pes_pkg::OP_CMD && (cmd == pes_pkg::CMD_UP
                                                  || cmd == pes_pkg::CMD_DOWN)) begin
                        n_clear_count = '0;
                        n_seen_clear  = 1'b0;
                    end else if (op == pes_pkg::OP_TICK) begin
                        n_clear_count = tick_count;
                        if (!i_req.beam_blocked) begin
                            n_seen_clear = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // leave for config: drop interval and total
            if (r_stage != pes_pkg::ST_CONFIG && n_stage == pes_pkg::ST_CONFIG) begin
                n_last = '0;
                n_acc  = '0;
            end
            // arm: drop total
            if ((r_stage == pes_pkg::ST_CONFIG || r_stage == pes_pkg::ST_ERROR)
                && n_stage == pes_pkg::ST_WAITING) begin
                n_acc = '0;
            end
            // enter error: restart the clear check
            if (r_stage == pes_pkg::ST_CONFIG && n_stage == pes_pkg::ST_ERROR) begin
                n_clear_count = '0;
                n_seen_clear  = 1'b0;
            end
        end
        if (i_cfg.option_load) begin
            n_option = i_cfg.option_load_value;
        end
    end

    always_comb begin
        n_res.stage_now     = n_stage;
        n_res.option_now    = n_option;
        n_res.elapsed_us    = i_cfg.accumulate_mode ? n_acc : n_last;
        n_res.reading_ready = ready_flag;
        n_res.lap_added     = lap_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage       <= pes_pkg::ST_CONFIG;
            r_option      <= pes_pkg::OPTION_DEFAULT_RST;
            r_start       <= '0;
            r_last        <= '0;
            r_acc         <= '0;
            r_clear_count <= '0;
            r_seen_clear  <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            r_stage       <= n_stage;
            r_option      <= n_option;
            r_start       <= n_start;
            r_last        <= n_last;
            r_acc         <= n_acc;
            r_clear_count <= n_clear_count;
            r_seen_clear  <= n_seen_clear;
            if (o_advance) begin
                r_res_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, r_res_valid,
                 !(r_res.reading_ready && r_res.lap_added))
    `ASSERT_IMPL(a_lap_rearms, i_clk, i_rst_n, r_res_valid && r_res.lap_added,
                 r_res.stage_now == pes_pkg::ST_WAITING)
    `ASSERT_NEXT(a_exit_holds, i_clk, i_rst_n, r_stage == pes_pkg::ST_EXIT,
                 r_stage == pes_pkg::ST_EXIT)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_clear_count <= CLEAR_MAX)

endmodule

/* sv/photogate_experiment_sequencer.sv */
// Top level of the photogate experiment sequencer
// One request is taken per clock while ready is high; each result passes through the input
// register and then the result register. Every request, of any kind, yields exactly one result.
// The stage, option and timing registers update once per request, which gives a throughput of
// one request per cycle; ready drops only while both the input and the result register hold
// items and the result is not being taken. Configuration is written through a plain write port.
module photogate_experiment_sequencer #(
    parameter int CLEAR_SAMPLES = pes_pkg::CLEAR_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pes_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [pes_pkg::DATA_W-1:0]  i_cfg_data,
    pes_req_if.sink                     i_req,
    pes_res_if.source                   o_res
);

    pes_pkg::t_cfg cfg;
    pes_pkg::t_req req_in;
    pes_pkg::t_req req_reg;
    pes_pkg::t_res res;
    logic          req_valid;
    logic          advance;
    logic          res_valid;
    logic          in_ready;

    assign req_in.op           = i_req.op;
    assign req_in.command      = i_req.command;
    assign req_in.timestamp_us = i_req.timestamp_us;
    assign req_in.beam_blocked = i_req.beam_blocked;
    assign i_req.ready         = in_ready;

    pes_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pes_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_req.valid),
        .i_req     (req_in),
        .o_ready   (in_ready),
        .i_advance (advance),
        .o_valid   (req_valid),
        .o_req     (req_reg)
    );

    pes_core #(
        .CLEAR_SAMPLES (CLEAR_SAMPLES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (req_valid),
        .i_req       (req_reg),
        .o_advance   (advance),
        .i_res_ready (o_res.ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_res.valid         = res_valid;
    assign o_res.stage_now     = res.stage_now;
    assign o_res.option_now    = res.option_now;
    assign o_res.elapsed_us    = res.elapsed_us;
    assign o_res.reading_ready = res.reading_ready;
    assign o_res.lap_added     = res.lap_added;

endmodule
